/* hw/rtl/shift_prng_range_assert.svh */
// ----------------------------------------------------------------------------
// shift_prng_range assertion macros
// concurrent check shorthands used by shift_prng_range
// ----------------------------------------------------------------------------
`ifndef SHIFT_PRNG_RANGE_ASSERT_SVH
`define SHIFT_PRNG_RANGE_ASSERT_SVH

// same-cycle implication, skipped while in reset
`define SPR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, skipped while in reset
`define SPR_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

/* hw/rtl/spr_pkg.sv */
// ----------------------------------------------------------------------------
// spr_pkg
// shared types and constants of the shift-register prng with range fold
// ----------------------------------------------------------------------------
package spr_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CntW  = $clog2(DataW);

  localparam logic [DataW-1:0] SEED_RESET = 32'h0000_0001;
  localparam logic [DataW-1:0] LOW12_MASK = 32'h0000_0fff;

  typedef struct packed {
    logic [DataW-1:0] low_bound;
    logic [DataW-1:0] high_bound;
  } spr_in_t;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic             span_error;
  } spr_out_t;

  typedef struct packed {
    logic start;
  } spr_div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } spr_div_stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_DIV,
    S_FINISH
  } spr_state_t;

  // one generator step: arithmetic shift right xor low bits moved up,
  // then fold the top 12 bits back into the bottom
  function automatic logic [DataW-1:0] seed_advance(input logic [DataW-1:0] s);
    logic [DataW-1:0] x;
    x = {s[DataW-1], s[DataW-1:1]} ^ {s[19:0], 12'h000};
    return x ^ ((x >> 20) & LOW12_MASK);
  endfunction

endpackage

/* hw/rtl/spr_div.sv */
// ----------------------------------------------------------------------------
// spr_div
// restoring remainder unit, dividend shifted in one bit per cycle
// ----------------------------------------------------------------------------
module spr_div (
  input  logic                       clk,
  input  logic                       rst,
  input  spr_pkg::spr_div_ctrl_t     ctrl,
  input  logic [spr_pkg::DataW-1:0]  dividend,
  input  logic [spr_pkg::DataW-1:0]  divisor,
  output spr_pkg::spr_div_stat_t     stat,
  output logic [spr_pkg::DataW-1:0]  remainder
);
  import spr_pkg::*;

  logic [DataW-1:0] dvd;
  logic [DataW-1:0] dsr;
  logic [DataW-1:0] rem;
  logic [CntW-1:0]  cnt;
  logic             busy;
  logic             done;

  logic [DataW:0]   shifted;
  logic [DataW:0]   trial;

  // partial remainder with the next dividend bit brought down
  assign shifted = {rem, dvd[DataW-1]};
  assign trial   = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      cnt <= CntW'(DataW - 1);
    end else if (busy) begin
      dvd <= {dvd[DataW-2:0], 1'b0};
      cnt <= cnt - 1'b1;
      // keep the difference unless it borrowed
      if (trial[DataW]) begin
        rem <= shifted[DataW-1:0];
      end else begin
        rem <= trial[DataW-1:0];
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign remainder = rem;

endmodule

/* hw/rtl/shift_prng_range.sv */
// ----------------------------------------------------------------------------
// shift_prng_range
// shift-register pseudo-random generator folded into a requested range
// ----------------------------------------------------------------------------
// each input beat carries a low and a high bound; the 32-bit seed takes one
// generator step on acceptance and the result beat returns
// low_bound + ((seed - low_bound) mod (high_bound - low_bound + 1)), all
// modulo 2^32. when the span wraps to zero the seed still steps, value is 0
// and span_error is set. writing cfg_wdata with cfg_wen loads the seed
// directly (reset value 1); write only while no request is in flight. one
// request is worked at a time, through acceptance, span setup, the
// bit-serial remainder unit, hand-off and result load; a zero span skips
// the remainder unit. the next request is accepted as soon as the result
// is loaded, even while the result beat is still stalled downstream.

module shift_prng_range (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  spr_pkg::spr_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output spr_pkg::spr_out_t         out_data,
  input  logic                      cfg_wen,
  input  logic [spr_pkg::DataW-1:0] cfg_wdata
);
  import spr_pkg::*;

  `include "shift_prng_range_assert.svh"

  spr_state_t       state;
  spr_state_t       state_next;

  logic [DataW-1:0] seed;
  logic [DataW-1:0] lo;
  logic [DataW-1:0] hi;
  logic [DataW-1:0] span;
  logic             span_err;

  logic [DataW-1:0] span_calc;
  logic [DataW-1:0] offset_calc;
  logic             in_take;
  logic             out_load;

  spr_div_ctrl_t    div_ctrl;
  spr_div_stat_t    div_stat;
  logic [DataW-1:0] div_rem;

  // request handshake
  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  // span and offset, both from registered operands
  assign span_calc   = hi - lo + 1'b1;
  assign offset_calc = seed - lo;

  spr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (div_ctrl),
    .dividend  (offset_calc),
    .divisor   (span_calc),
    .stat      (div_stat),
    .remainder (div_rem)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    div_ctrl.start = 1'b0;
    out_load       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        // zero span skips the divider entirely
        if (span_calc == '0) begin
          state_next = S_FINISH;
        end else begin
          div_ctrl.start = 1'b1;
          state_next     = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // wait for the result register to be free
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // seed: reset value, config load, one step per accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (cfg_wen) begin
      seed <= cfg_wdata;
    end else if (in_take) begin
      seed <= seed_advance(seed);
    end
  end

  // operand capture
  always_ff @(posedge clk) begin
    if (in_take) begin
      lo <= in_data.low_bound;
      hi <= in_data.high_bound;
    end
    if (state == S_SETUP) begin
      span     <= span_calc;
      span_err <= (span_calc == '0);
    end
  end

  // result register, parts the sequencer from the output stall
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.span_error <= span_err;
      out_data.value      <= span_err ? '0 : (lo + div_rem);
    end
  end

  // checks
  `SPR_ASSERT_NXT(a_take_setup, clk, rst, in_take, state == S_SETUP)
  `SPR_ASSERT_IMP(a_done_in_div, clk, rst, div_stat.done, state == S_DIV)
  `SPR_ASSERT_IMP(a_rem_below_span, clk, rst, (state == S_FINISH) && !span_err,
                  div_rem < span)
  `SPR_ASSERT_IMP(a_err_zero, clk, rst, out_valid && out_data.span_error,
                  out_data.value == '0)

endmodule
